>>> rtl/scoll_pkg.sv
// Shared types and codes for the shape collision tester.
// No dependencies; every other file takes names from here by scope.
package scoll_pkg;

   localparam logic CMD_SHAPE   = 1'b0;
   localparam logic CMD_POINT   = 1'b1;
   localparam logic KIND_BOX    = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   typedef struct packed {
      logic valid;
      logic use_dist;
      logic strict;
      logic flag_hit;
   } stage_ctl_type;

endpackage

>>> rtl/scoll_geom.sv
// Geometry stage: interval tests, circle centers, clamping and distance magnitudes.
// Depends on scoll_pkg; registers its results for scoll_dist.
module scoll_geom #(
   parameter int COORD_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic                               command,
   input  logic                               a_kind,
   input  logic signed [COORD_BITS-1:0]       a_x,
   input  logic signed [COORD_BITS-1:0]       a_y,
   input  logic        [COORD_BITS-2:0]       a_width,
   input  logic        [COORD_BITS-2:0]       a_height,
   input  logic                               b_kind,
   input  logic signed [COORD_BITS-1:0]       b_x,
   input  logic signed [COORD_BITS-1:0]       b_y,
   input  logic        [COORD_BITS-2:0]       b_width,
   input  logic        [COORD_BITS-2:0]       b_height,
   output scoll_pkg::stage_ctl_type           ctl_out,
   output logic        [COORD_BITS+1:0]       mag_x,
   output logic        [COORD_BITS+1:0]       mag_y,
   output logic        [COORD_BITS-1:0]       rad
);

   localparam int EW  = COORD_BITS + 4;
   localparam int SP  = EW - COORD_BITS;
   localparam int ZP  = EW - COORD_BITS + 1;
   localparam int MW  = COORD_BITS + 2;

   logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e;
   logic signed [EW-1:0] aw_e, ah_e, bw_e, bh_e;
   logic signed [EW-1:0] ra_e, rb_e;
   logic signed [EW-1:0] cx, cy, ocx, ocy, dcx, dcy, clx, cly, dx, dy, dx_abs, dy_abs;
   logic        [COORD_BITS-2:0] ra, rb;
   logic point_hit, box_hit;

   scoll_pkg::stage_ctl_type ctl_in, ctl_ff;
   logic [MW-1:0]         mag_x_in, mag_y_in, mag_x_ff, mag_y_ff;
   logic [COORD_BITS-1:0] rad_in, rad_ff;

   always_comb begin
      ax_e = {{SP{a_x[COORD_BITS-1]}}, a_x};
      ay_e = {{SP{a_y[COORD_BITS-1]}}, a_y};
      bx_e = {{SP{b_x[COORD_BITS-1]}}, b_x};
      by_e = {{SP{b_y[COORD_BITS-1]}}, b_y};
      aw_e = {{ZP{1'b0}}, a_width};
      ah_e = {{ZP{1'b0}}, a_height};
      bw_e = {{ZP{1'b0}}, b_width};
      bh_e = {{ZP{1'b0}}, b_height};

      point_hit = (bx_e >= ax_e - aw_e) && (bx_e <= ax_e + aw_e) &&
                  (by_e <= ay_e + ah_e) && (by_e >= ay_e - ah_e);
      box_hit = !((ax_e - aw_e > bx_e + bw_e) || (bx_e - bw_e > ax_e + aw_e) ||
                  (ay_e + ah_e < by_e - bh_e) || (by_e + bh_e < ay_e - ah_e));

      ra   = (a_width >= a_height) ? a_width : a_height;
      rb   = (b_width >= b_height) ? b_width : b_height;
      ra_e = {{ZP{1'b0}}, ra};
      rb_e = {{ZP{1'b0}}, rb};
      cx   = (ax_e <<< 1) + ra_e;
      cy   = (ay_e <<< 1) + ra_e;

      // center of B: box spans position to position + size, circle as for A
      if (b_kind == scoll_pkg::KIND_BOX) begin
         ocx = (bx_e <<< 1) + bw_e;
         ocy = (by_e <<< 1) + bh_e;
      end else begin
         ocx = (bx_e <<< 1) + rb_e;
         ocy = (by_e <<< 1) + rb_e;
      end
      dcx = cx - ocx;
      dcy = cy - ocy;

      if (dcx < -bw_e)     clx = -bw_e;
      else if (dcx > bw_e) clx = bw_e;
      else                 clx = dcx;
      if (dcy < -bh_e)     cly = -bh_e;
      else if (dcy > bh_e) cly = bh_e;
      else                 cly = dcy;

      if (b_kind == scoll_pkg::KIND_BOX) begin
         dx     = clx - dcx;
         dy     = cly - dcy;
         rad_in = {1'b0, ra};
      end else begin
         dx     = dcx;
         dy     = dcy;
         rad_in = {1'b0, ra} + {1'b0, rb};
      end
      dx_abs   = dx[EW-1] ? -dx : dx;
      dy_abs   = dy[EW-1] ? -dy : dy;
      mag_x_in = dx_abs[MW-1:0];
      mag_y_in = dy_abs[MW-1:0];

      ctl_in.valid    = in_valid;
      ctl_in.use_dist = (command == scoll_pkg::CMD_SHAPE) && (a_kind == scoll_pkg::KIND_CIRCLE);
      ctl_in.strict   = (b_kind == scoll_pkg::KIND_BOX);
      ctl_in.flag_hit = (command == scoll_pkg::CMD_POINT) ? point_hit : box_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      rad_ff   <= rad_in;
   end

   assign ctl_out = ctl_ff;
   assign mag_x   = mag_x_ff;
   assign mag_y   = mag_y_ff;
   assign rad     = rad_ff;

endmodule

>>> rtl/scoll_dist.sv
// Distance stage: registered squares, then sum, compare and result register.
// Depends on scoll_pkg; fed by scoll_geom.
module scoll_dist #(
   parameter int COORD_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  scoll_pkg::stage_ctl_type    ctl_in,
   input  logic [COORD_BITS+1:0]       mag_x,
   input  logic [COORD_BITS+1:0]       mag_y,
   input  logic [COORD_BITS-1:0]       rad,
   output logic                        out_valid,
   output logic                        out_hit
);

   localparam int MW = COORD_BITS + 2;
   localparam int SW = 2 * MW;
   localparam int RW = 2 * COORD_BITS;

   scoll_pkg::stage_ctl_type ctl_ff;
   logic [SW-1:0] sq_x_in, sq_y_in, sq_x_ff, sq_y_ff;
   logic [RW-1:0] sq_r_in, sq_r_ff;
   logic [SW:0]   d2, r2;
   logic          hit_in, hit_ff, valid_ff;

   assign sq_x_in = SW'(mag_x) * SW'(mag_x);
   assign sq_y_in = SW'(mag_y) * SW'(mag_y);
   assign sq_r_in = RW'(rad) * RW'(rad);

   always_comb begin
      d2 = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      r2 = (SW+1)'(sq_r_ff);
      if (!ctl_ff.use_dist)  hit_in = ctl_ff.flag_hit;
      else if (ctl_ff.strict) hit_in = (d2 < r2);
      else                    hit_in = (d2 <= r2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         ctl_ff   <= ctl_in;
         valid_ff <= ctl_ff.valid;
      end
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_r_ff <= sq_r_in;
      hit_ff  <= hit_in;
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

endmodule

>>> rtl/shape_collision_tester_top.sv
// Top level of the shape collision tester: input register, geometry and distance stages.
// Depends on scoll_pkg, scoll_geom and scoll_dist.
//
// One query is taken on every clock edge where start is high and busy is low; busy is
// high during reset and in the cycle after it, so the block sustains one item per cycle.
// The hit flag appears on rsp_hit with rsp_valid high for one cycle, once the item has
// passed the input register, geometry stage, square multipliers, then compare and
// result register. Results arrive in order and cannot be held off by the receiver.
module shape_collision_tester_top #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic                         req_a_kind,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic        [COORD_BITS-2:0] req_a_width,
   input  logic        [COORD_BITS-2:0] req_a_height,
   input  logic                         req_b_kind,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic        [COORD_BITS-2:0] req_b_width,
   input  logic        [COORD_BITS-2:0] req_b_height,
   output logic                         rsp_valid,
   output logic                         rsp_hit
);

   logic req_accept;
   logic busy_ff, valid_ff;
   logic command_ff, a_kind_ff, b_kind_ff;
   logic signed [COORD_BITS-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic        [COORD_BITS-2:0] a_width_ff, a_height_ff, b_width_ff, b_height_ff;

   scoll_pkg::stage_ctl_type s1_ctl;
   logic [COORD_BITS+1:0]    s1_mag_x, s1_mag_y;
   logic [COORD_BITS-1:0]    s1_rad;

   assign req_accept = start && !busy_ff;
   assign busy       = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_accept;
      end
      if (req_accept) begin
         command_ff  <= req_command;
         a_kind_ff   <= req_a_kind;
         a_x_ff      <= req_a_x;
         a_y_ff      <= req_a_y;
         a_width_ff  <= req_a_width;
         a_height_ff <= req_a_height;
         b_kind_ff   <= req_b_kind;
         b_x_ff      <= req_b_x;
         b_y_ff      <= req_b_y;
         b_width_ff  <= req_b_width;
         b_height_ff <= req_b_height;
      end
   end

   scoll_geom #(.COORD_BITS(COORD_BITS)) u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_ff),
      .command  (command_ff),
      .a_kind   (a_kind_ff),
      .a_x      (a_x_ff),
      .a_y      (a_y_ff),
      .a_width  (a_width_ff),
      .a_height (a_height_ff),
      .b_kind   (b_kind_ff),
      .b_x      (b_x_ff),
      .b_y      (b_y_ff),
      .b_width  (b_width_ff),
      .b_height (b_height_ff),
      .ctl_out  (s1_ctl),
      .mag_x    (s1_mag_x),
      .mag_y    (s1_mag_y),
      .rad      (s1_rad)
   );

   scoll_dist #(.COORD_BITS(COORD_BITS)) u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (s1_ctl),
      .mag_x     (s1_mag_x),
      .mag_y     (s1_mag_y),
      .rad       (s1_rad),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit)
   );

   a_rsp_has_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, 4))
      else $error("result strobe without an item taken four cycles earlier");

   a_not_busy : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy outside the cycle after reset");

   a_point_on_center : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == scoll_pkg::CMD_POINT &&
       req_b_x == req_a_x && req_b_y == req_a_y) |-> ##4 (rsp_valid && rsp_hit))
      else $error("point at box position reported as miss");

   a_box_same_place : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == scoll_pkg::CMD_SHAPE &&
       req_a_kind == scoll_pkg::KIND_BOX &&
       req_b_x == req_a_x && req_b_y == req_a_y) |-> ##4 (rsp_valid && rsp_hit))
      else $error("coincident box test reported as miss");

endmodule
